FILE: rtl/mhba_pkg.sv
`timescale 1ns / 1ps
package mhba_pkg;

  // Table geometry
  localparam int COUNT_BITS  = 16;
  localparam int SAMPLE_BITS = 12;
  localparam int SUM_W       = COUNT_BITS + SAMPLE_BITS;
  localparam int NUM_MONTHS  = 12;
  localparam int NUM_HOURS   = 24;
  localparam int NUM_BINS    = NUM_MONTHS * NUM_HOURS;
  localparam int IDX_W       = $clog2(NUM_BINS);
  localparam int ENTRY_W     = SUM_W + COUNT_BITS;

  // Item field widths
  localparam int MONTH_W     = 4;
  localparam int HOUR_W      = 5;
  localparam int SOLAR_W     = 12;
  localparam int MEAN_W      = 12;
  localparam int CNT_OUT_W   = 16;
  localparam int S_TDATA_W   = 24;
  localparam int M_TDATA_W   = 32;

  // Divider widths: numerator 2*sum+n, divisor 2*n, quotient fits SAMPLE_BITS
  localparam int NUM_W       = SUM_W + 2;
  localparam int DEN_W       = COUNT_BITS + 1;
  localparam int REM_W       = COUNT_BITS + 2;
  localparam int STEP_W      = $clog2(SAMPLE_BITS + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Item kinds
  localparam logic MODE_ACC   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

endpackage

FILE: rtl/month_hour_binned_average.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake                    Payload (lowest bit first)
// s_axis    in   s_axis_tvalid_i/tready_o     tuser: mode; tdata: month, hour, solar
// m_axis    out  m_axis_tvalid_o/tready_i     tuser: bin_empty; tdata: mean, count
//
// Accumulate: read, then write back of one table entry.
// Query: read, divide, then output; the restoring divider resolves one quotient bit a cycle.
// A query on an empty bin skips the divider.
// Items with a bad month or hour are taken and dropped.
// After reset all NUM_BINS (288) table entries are swept to zero; no item is taken then.
// A finished result waits in the output register; accumulations go on meanwhile, and a
// later query holds in its last cycle, with the input closed, until that register drains.
module month_hour_binned_average
  import mhba_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,  // month_number[3:0], hour_of_day[8:4],
                                                // solar_value[20:9], zero[23:21]
  input  logic                 s_axis_tuser_i,  // mode
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,  // mean_value[11:0], sample_count[27:12],
                                                // zero[31:28]
  output logic                 m_axis_tuser_o   // bin_empty
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [IDX_W-1:0] clr_q, clr_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic mode_q, mode_d;
  logic [SAMPLE_BITS-1:0] sample_q, sample_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [SAMPLE_BITS-1:0] quo_q, quo_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic out_valid_q, out_valid_d;
  logic [MEAN_W-1:0] out_mean_q, out_mean_d;
  logic [CNT_OUT_W-1:0] out_cnt_q, out_cnt_d;
  logic out_empty_q, out_empty_d;

  logic [ENTRY_W-1:0] mem [NUM_BINS];
  logic [ENTRY_W-1:0] rd_q;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic wr_en;

  logic [MONTH_W-1:0] in_month;
  logic [HOUR_W-1:0] in_hour;
  logic [SOLAR_W-1:0] in_solar;
  logic [MONTH_W-1:0] month_m1;
  logic bin_ok;
  logic accept;
  logic [SUM_W-1:0] rd_sum;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [NUM_W-1:0] num;
  logic [REM_W-1:0] trial;
  logic trial_ge;

  assign in_month = s_axis_tdata_i[MONTH_W-1:0];
  assign in_hour  = s_axis_tdata_i[MONTH_W+HOUR_W-1:MONTH_W];
  assign in_solar = s_axis_tdata_i[MONTH_W+HOUR_W+SOLAR_W-1:MONTH_W+HOUR_W];
  assign month_m1 = in_month - MONTH_W'(1);
  assign bin_ok   = (in_month >= MONTH_W'(1)) && (in_month <= MONTH_W'(NUM_MONTHS))
                 && (in_hour < HOUR_W'(NUM_HOURS));
  assign rd_addr  = IDX_W'(month_m1) * IDX_W'(NUM_HOURS) + IDX_W'(in_hour);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  assign rd_sum = rd_q[ENTRY_W-1:COUNT_BITS];
  assign rd_cnt = rd_q[COUNT_BITS-1:0];
  assign num    = {1'b0, rd_sum, 1'b0} + NUM_W'(rd_cnt);

  assign trial    = {rem_q[REM_W-2:0], quo_q[SAMPLE_BITS-1]};
  assign trial_ge = (trial >= REM_W'(den_q));

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    idx_d       = idx_q;
    mode_d      = mode_q;
    sample_d    = sample_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    den_d       = den_q;
    quo_d       = quo_q;
    step_d      = step_q;
    out_mean_d  = out_mean_q;
    out_cnt_d   = out_cnt_q;
    out_empty_d = out_empty_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    wr_en       = 1'b0;
    wr_addr     = idx_q;
    wr_data     = '0;

    case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        if (clr_q == IDX_W'(NUM_BINS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + IDX_W'(1);
        end
      end
      ST_IDLE: begin
        if (accept && bin_ok) begin
          idx_d    = rd_addr;
          mode_d   = s_axis_tuser_i;
          sample_d = in_solar[SAMPLE_BITS-1:0];
          state_d  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (mode_q == MODE_ACC) begin
          // Saturate: a full bin keeps its sum and count
          if (rd_cnt != COUNT_MAX) begin
            wr_en   = 1'b1;
            wr_data = {rd_sum + SUM_W'(sample_q), rd_cnt + COUNT_BITS'(1)};
          end
          state_d = ST_IDLE;
        end else begin
          cnt_d  = rd_cnt;
          den_d  = {rd_cnt, 1'b0};
          rem_d  = num[NUM_W-1:SAMPLE_BITS];
          quo_d  = num[SAMPLE_BITS-1:0];
          step_d = '0;
          if (rd_cnt == '0) begin
            quo_d   = '0;
            state_d = ST_DONE;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        // Shift in the next numerator bit, subtract when it fits
        rem_d = trial_ge ? (trial - REM_W'(den_q)) : trial;
        quo_d = {quo_q[SAMPLE_BITS-2:0], trial_ge};
        if (step_q == STEP_W'(SAMPLE_BITS - 1)) begin
          state_d = ST_DONE;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_mean_d  = MEAN_W'(quo_q);
          out_cnt_d   = CNT_OUT_W'(cnt_q);
          out_empty_d = (cnt_q == '0);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    mode_q      <= mode_d;
    sample_q    <= sample_d;
    cnt_q       <= cnt_d;
    rem_q       <= rem_d;
    den_q       <= den_d;
    quo_q       <= quo_d;
    step_q      <= step_d;
    out_mean_q  <= out_mean_d;
    out_cnt_q   <= out_cnt_d;
    out_empty_q <= out_empty_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(M_TDATA_W - MEAN_W - CNT_OUT_W)'(0), out_cnt_q, out_mean_q};
  assign m_axis_tuser_o  = out_empty_q;

endmodule

FILE: rtl/mhba_checker.sv
`timescale 1ns / 1ps
module mhba_checker
  import mhba_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid_i,
  input logic                 s_axis_tready_o,
  input logic [S_TDATA_W-1:0] s_axis_tdata_i,
  input logic                 s_axis_tuser_i,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [M_TDATA_W-1:0] m_axis_tdata_o,
  input logic                 m_axis_tuser_o
);

  logic in_bin_ok;
  assign in_bin_ok = (s_axis_tdata_i[MONTH_W-1:0] >= MONTH_W'(1))
                  && (s_axis_tdata_i[MONTH_W-1:0] <= MONTH_W'(NUM_MONTHS))
                  && (s_axis_tdata_i[MONTH_W+HOUR_W-1:MONTH_W] < HOUR_W'(NUM_HOURS));

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // An empty bin reports zero mean and zero count
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("empty bin with nonzero payload");

  // A nonempty bin reports a nonzero count
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |->
      m_axis_tdata_o[MEAN_W+CNT_OUT_W-1:MEAN_W] != '0)
    else $error("nonempty bin with zero count");

  // A transaction on a valid bin keeps the input closed in the next cycle
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && in_bin_ok |=> !s_axis_tready_o)
    else $error("input ready during table update");

endmodule

bind month_hour_binned_average mhba_checker u_mhba_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
